// ----- src/lsve_pkg.sv -----
// ----------------------------------------------------------------------------
// lsve_pkg: shared constants and types of the long shadow vertex expander
// Field widths, stream packing widths and configuration register indexes.
// ----------------------------------------------------------------------------
package lsve_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int CH_W    = 8;
  localparam int IDX_W   = 6;
  localparam int SEG_W   = 6;
  localparam int CFG_W   = 32;
  localparam int N_AXES  = 3;
  localparam int N_CH    = 4;
  localparam int CH_A    = 3;

  // setup divider: one quotient bit per cycle over a 32-bit dividend
  localparam int DVD_W = 32;
  localparam int DC_W  = $clog2(DVD_W);

  // stream packing
  localparam int IN_FIELDS_W  = N_AXES * COORD_W + CH_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = N_AXES * COORD_W + N_CH * CH_W + IDX_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_OFFSET_X       = 3'd0,
    REG_OFFSET_Y       = 3'd1,
    REG_OFFSET_Z       = 3'd2,
    REG_SHADOW_RGBA    = 3'd3,
    REG_GRADIENT_RGBA  = 3'd4,
    REG_SEGMENTS       = 3'd5,
    REG_USE_GRADIENT   = 3'd6,
    REG_MULTIPLY_ALPHA = 3'd7
  } reg_index_t;

endpackage

// ----- src/long_shadow_vertex_expander_top.sv -----
// ----------------------------------------------------------------------------
// long_shadow_vertex_expander_top: long shadow extrusion of UI vertices
// Expands each vertex into segments+1 displaced, colored shadow copies.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one vertex per beat (x, y, z Q16.16 and source alpha).
//   m_axis: one shadow copy per beat, copy 0 (farthest) first, tlast on the
//           final copy of each vertex.
//   cfg:    write enable, register index and data; writes take effect at once;
//           the user must make them only while the block is idle; the block does not enforce this.
// Throughput: one copy per cycle while m_axis does not stall; the next
//   vertex is taken on the cycle its predecessor's last copy is issued.
//   The copy generator feeds the four stage copy pipeline (stages 1 to 3
//   and the output register) that drives m_axis.
// Reset and configuration: after reset and after every register write a
//   setup pass divides each offset magnitude and the
//   reciprocal constant by the copy count (one quotient bit per cycle);
//   s_axis_tready stays low during it.
// Stall: when m_axis_tready is low with a copy pending, the whole copy
//   pipeline and the generator freeze; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module long_shadow_vertex_expander_top #(
  parameter int MAX_SEGMENTS = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  // vertex stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: in_x[31:0], in_y[31:0], in_z[31:0], source_alpha[7:0]
  input  logic [lsve_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // shadow copy stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: out_x[31:0], out_y[31:0], out_z[31:0], red, green,
  // blue, alpha (8 each), copy_index[5:0], zero fill
  output logic [lsve_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  // configuration write port
  input  logic                              cfg_we,
  input  lsve_pkg::reg_index_t              cfg_index,
  input  logic [lsve_pkg::CFG_W-1:0]        cfg_data
);
  import lsve_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 2);
  localparam int RSH    = CH_W + 2 * CNT_W;
  localparam int NUM_W  = CH_W + CNT_W;
  localparam int FRAC_W = 2 * CNT_W;

  // configuration registers
  logic [COORD_W-1:0] offset_x, offset_y, offset_z;
  logic [CFG_W-1:0]   shadow_rgba, gradient_rgba;
  logic [SEG_W-1:0]   segments;
  logic               use_gradient, multiply_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x       <= '0;
      offset_y       <= '0;
      offset_z       <= '0;
      shadow_rgba    <= CFG_W'(255);
      gradient_rgba  <= CFG_W'(255);
      segments       <= '0;
      use_gradient   <= 1'b0;
      multiply_alpha <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_X:       offset_x       <= cfg_data[COORD_W-1:0];
        REG_OFFSET_Y:       offset_y       <= cfg_data[COORD_W-1:0];
        REG_OFFSET_Z:       offset_z       <= cfg_data[COORD_W-1:0];
        REG_SHADOW_RGBA:    shadow_rgba    <= cfg_data;
        REG_GRADIENT_RGBA:  gradient_rgba  <= cfg_data;
        REG_SEGMENTS:       segments       <= cfg_data[SEG_W-1:0];
        REG_USE_GRADIENT:   use_gradient   <= cfg_data[0];
        REG_MULTIPLY_ALPHA: multiply_alpha <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // derived setup values
  logic [SEG_W-1:0]   seg_c;
  logic [CNT_W-1:0]   count;
  logic [COORD_W-1:0] offs    [N_AXES];
  logic [COORD_W-1:0] off_mag [N_AXES];
  logic [CH_W-1:0]    sh_ch   [N_CH];
  logic [CH_W-1:0]    gr_ch   [N_CH];

  assign seg_c = (segments > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : segments;
  assign count = CNT_W'(seg_c) + CNT_W'(1);
  assign offs[0] = offset_x;
  assign offs[1] = offset_y;
  assign offs[2] = offset_z;

  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      off_mag[i] = offs[i][COORD_W-1] ? (~offs[i] + COORD_W'(1)) : offs[i];
    end
    // red in the top byte, alpha in the bottom byte
    for (int c = 0; c < N_CH; c++) begin
      sh_ch[c] = shadow_rgba[CH_W*(N_CH-1-c) +: CH_W];
      gr_ch[c] = gradient_rgba[CH_W*(N_CH-1-c) +: CH_W];
    end
  end

  // setup divider: lanes 0..2 divide offset magnitudes, lane 3 gives the
  // reciprocal (2^RSH - 1) / count; all by count, restoring, bit serial
  localparam int NL = N_AXES + 1;
  localparam logic [DVD_W-1:0] RCP_DVD = {{(DVD_W-RSH){1'b0}}, {RSH{1'b1}}};

  logic            div_pend, busy;
  logic [DC_W-1:0] div_cnt;
  logic [DVD_W-1:0] dvd       [NL];
  logic [CNT_W-1:0] drem      [NL];
  logic [DVD_W-1:0] dvd_next  [NL];
  logic [CNT_W-1:0] drem_next [NL];

  always_comb begin
    logic [CNT_W:0] rem_w;
    logic           ge;
    for (int l = 0; l < NL; l++) begin
      rem_w        = {drem[l], dvd[l][DVD_W-1]};
      ge           = (rem_w >= {1'b0, count});
      drem_next[l] = ge ? CNT_W'(rem_w - {1'b0, count}) : CNT_W'(rem_w);
      dvd_next[l]  = {dvd[l][DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pend <= 1'b1;
      busy     <= 1'b1;
      div_cnt  <= '0;
    end else if (cfg_we) begin
      div_pend <= 1'b1;
      busy     <= 1'b1;
    end else if (div_pend) begin
      div_pend <= 1'b0;
      div_cnt  <= '0;
    end else if (busy) begin
      div_cnt <= div_cnt + DC_W'(1);
      if (div_cnt == DC_W'(DVD_W - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_pend) begin
      for (int i = 0; i < N_AXES; i++) dvd[i] <= off_mag[i];
      dvd[N_AXES] <= RCP_DVD;
      for (int l = 0; l < NL; l++) drem[l] <= '0;
    end else if (busy) begin
      for (int l = 0; l < NL; l++) begin
        dvd[l]  <= dvd_next[l];
        drem[l] <= drem_next[l];
      end
    end
  end

  // ceil(2^RSH / count), exact quotients for numerators below 2^NUM_W
  logic [RSH:0] rcp;
  assign rcp = dvd[N_AXES][RSH:0] + (RSH+1)'(1);

  // copy generator
  logic               adv;
  logic               act, last_k, issue, in_acc;
  logic [CNT_W-1:0]   k, rem;
  logic [COORD_W-1:0] vpos [N_AXES];
  logic [CH_W-1:0]    vsrc;

  assign last_k        = (k == CNT_W'(seg_c));
  assign rem           = count - k;
  assign issue         = act && adv;
  assign s_axis_tready = !busy && (!act || (adv && last_k));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      k   <= '0;
    end else if (in_acc) begin
      act <= 1'b1;
      k   <= '0;
    end else if (issue) begin
      k <= k + CNT_W'(1);
      if (last_k) act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < N_AXES; i++) vpos[i] <= s_axis_tdata[COORD_W*i +: COORD_W];
      vsrc <= s_axis_tdata[N_AXES*COORD_W +: CH_W];
    end
  end

  // pipeline advances whenever the output register is free or taken
  logic o_valid;
  assign adv = !o_valid || m_axis_tready;

  // stage 1: integer part rem*Q, fraction numerator rem*R, color numerators
  logic                     s1_valid, s1_last;
  logic [CNT_W-1:0]         s1_k;
  logic [CH_W-1:0]          s1_src;
  logic [COORD_W-1:0]       s1_pos [N_AXES];
  logic [COORD_W-1:0]       s1_px  [N_AXES];
  logic [FRAC_W-1:0]        s1_fn  [N_AXES];
  logic [NUM_W-1:0]         s1_cn  [N_CH];
  logic [DVD_W+CNT_W-1:0]   pxp    [N_AXES];
  logic [FRAC_W-1:0]        fnp    [N_AXES];
  logic [NUM_W-1:0]         cnp    [N_CH];

  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      pxp[i] = dvd[i] * rem;
      fnp[i] = FRAC_W'(drem[i]) * FRAC_W'(rem);
    end
    for (int c = 0; c < N_CH; c++) begin
      cnp[c] = use_gradient ? (NUM_W'(sh_ch[c]) * NUM_W'(k) + NUM_W'(gr_ch[c]) * NUM_W'(rem))
                            : NUM_W'(sh_ch[c]);
    end
  end

  // stage 2: fraction and color quotients through the reciprocal (colors pass as is without gradient)
  logic                     s2_valid, s2_last;
  logic [CNT_W-1:0]         s2_k;
  logic [CH_W-1:0]          s2_src;
  logic [COORD_W-1:0]       s2_pos [N_AXES];
  logic [COORD_W-1:0]       s2_px  [N_AXES];
  logic [CNT_W-1:0]         s2_fq  [N_AXES];
  logic [CH_W-1:0]          s2_col [N_CH];
  logic [FRAC_W+RSH:0]      fqp    [N_AXES];
  logic [NUM_W+RSH:0]       cqp    [N_CH];

  always_comb begin
    for (int i = 0; i < N_AXES; i++) fqp[i] = s1_fn[i] * rcp;
    for (int c = 0; c < N_CH; c++)   cqp[c] = s1_cn[c] * rcp;
  end

  // stage 3: displacement magnitude, alpha product
  logic                     s3_valid, s3_last;
  logic [CNT_W-1:0]         s3_k;
  logic [COORD_W-1:0]       s3_pos [N_AXES];
  logic [COORD_W-1:0]       s3_mag [N_AXES];
  logic [CH_W-1:0]          s3_col [N_CH];
  logic [2*CH_W-1:0]        s3_am;

  // stage 4 (output): signed position update, alpha / 255
  logic [COORD_W-1:0]       o_pos [N_AXES];
  logic [CH_W-1:0]          o_col [N_CH];
  logic [CNT_W-1:0]         o_k;
  logic                     o_last;
  logic [2*CH_W:0]          adiv;

  assign adiv = (2*CH_W+1)'(s3_am) + (2*CH_W+1)'(s3_am >> CH_W) + (2*CH_W+1)'(1);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      o_valid  <= s3_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      s1_k    <= k;
      s1_last <= last_k;
      s1_src  <= vsrc;
      for (int i = 0; i < N_AXES; i++) begin
        s1_pos[i] <= vpos[i];
        s1_px[i]  <= pxp[i][COORD_W-1:0];
        s1_fn[i]  <= fnp[i];
      end
      for (int c = 0; c < N_CH; c++) s1_cn[c] <= cnp[c];
      // stage 2
      s2_k    <= s1_k;
      s2_last <= s1_last;
      s2_src  <= s1_src;
      for (int i = 0; i < N_AXES; i++) begin
        s2_pos[i] <= s1_pos[i];
        s2_px[i]  <= s1_px[i];
        s2_fq[i]  <= fqp[i][RSH +: CNT_W];
      end
      for (int c = 0; c < N_CH; c++) begin
        s2_col[c] <= use_gradient ? cqp[c][RSH +: CH_W] : s1_cn[c][CH_W-1:0];
      end
      // stage 3
      s3_k    <= s2_k;
      s3_last <= s2_last;
      s3_am   <= s2_src * s2_col[CH_A];
      for (int i = 0; i < N_AXES; i++) begin
        s3_pos[i] <= s2_pos[i];
        s3_mag[i] <= s2_px[i] + COORD_W'(s2_fq[i]);
      end
      for (int c = 0; c < N_CH; c++) s3_col[c] <= s2_col[c];
      // stage 4
      o_k    <= s3_k;
      o_last <= s3_last;
      for (int i = 0; i < N_AXES; i++) begin
        o_pos[i] <= offs[i][COORD_W-1] ? (s3_pos[i] - s3_mag[i]) : (s3_pos[i] + s3_mag[i]);
      end
      for (int c = 0; c < N_CH - 1; c++) o_col[c] <= s3_col[c];
      o_col[CH_A] <= multiply_alpha ? adiv[CH_W +: CH_W] : s3_col[CH_A];
    end
  end

  // output beat
  assign m_axis_tvalid = o_valid;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, IDX_W'(o_k),
                          o_col[3], o_col[2], o_col[1], o_col[0],
                          o_pos[2], o_pos[1], o_pos[0]};

endmodule

// ----- src/lsve_checker.sv -----
// ----------------------------------------------------------------------------
// lsve_checker: port-level checks of the long shadow vertex expander
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
module lsve_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lsve_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            cfg_we
);
  import lsve_pkg::*;

  // a stalled copy beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("copy beat changed while stalled");

  // reset empties the copy pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("copy beat valid right after reset");

  // reset starts the setup pass, so no vertex is taken
  a_rst_setup: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("vertex accepted before setup pass");

  // every register write restarts the setup pass
  a_cfg_setup: assert property (@(posedge clk)
    cfg_we |=> !s_axis_tready)
    else $error("vertex accepted during setup after a register write");

endmodule

bind long_shadow_vertex_expander_top lsve_checker u_lsve_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_we        (cfg_we)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the long shadow vertex expander
// Vertices go in on s_axis and every shadow copy coming back on m_axis is
// compared against copies extruded by a local model of the expander. The run
// covers the reset settings, directed corner cases, a long output hold-off
// and randomized configuration phases under random bursts and stalls.
// ----------------------------------------------------------------------------
module tb;
  import lsve_pkg::*;

  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 12;
  localparam int RANDOM_PHASES = 8;
  localparam int VERTS_PER_PHASE = 40;

  // one expected shadow copy; color[0] is red, color[3] is alpha
  typedef struct packed {
    logic [N_AXES-1:0][COORD_W-1:0] pos;
    logic [N_CH-1:0][CH_W-1:0]      color;
    logic [IDX_W-1:0]               idx;
    logic                           last;
  } shadow_copy_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // from bit 0: in_x, in_y, in_z, source_alpha
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // from bit 0: out_x, out_y, out_z, red, green, blue, alpha, copy_index, fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  reg_index_t            cfg_index = REG_OFFSET_X;
  logic [CFG_W-1:0]      cfg_data = '0;

  // local copy of the register file
  logic [N_AXES-1:0][COORD_W-1:0] disp_cfg;
  logic [31:0] shadow_cfg;
  logic [31:0] gradient_cfg;
  logic [SEG_W-1:0] seg_cfg;
  logic gradient_on;
  logic alpha_mul_on;

  shadow_copy_t pending_copies[$];
  int unsigned mismatches = 0;

  // sender burst and receiver stall control
  bit tx_gap_en = 1'b0;
  bit rx_stall_en = 1'b0;
  int unsigned burst_left = 0;
  logic hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_run_left = 0;

  long_shadow_vertex_expander_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // extrude one vertex into its shadow copies under the current registers
  function automatic void extrude_vertex(logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz, logic [7:0] src_a);
    shadow_copy_t c;
    logic [N_AXES-1:0][COORD_W-1:0] pos;
    int unsigned count, rem, s, g, mix;
    longint step;
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
    count = seg_cfg + 1;
    for (int unsigned k = 0; k < count; k++) begin
      rem = count - k;
      for (int a = 0; a < N_AXES; a++) begin
        // signed division truncates toward zero
        step = (longint'($signed(disp_cfg[a])) * longint'(rem)) / longint'(count);
        c.pos[a] = pos[a] + step[31:0];
      end
      for (int ch = 0; ch < N_CH; ch++) begin
        s = (shadow_cfg >> (24 - 8 * ch)) & 32'hFF;
        g = (gradient_cfg >> (24 - 8 * ch)) & 32'hFF;
        mix = gradient_on ? (s * k + g * rem) / count : s;
        c.color[ch] = mix[7:0];
      end
      if (alpha_mul_on)
        c.color[CH_A] = 8'((int'(src_a) * int'(c.color[CH_A])) / 255);
      c.idx = k[IDX_W-1:0];
      c.last = (k + 1 == count);
      pending_copies.push_back(c);
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want_v,
                                        logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %h, got %h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // full-range word with a bias toward the extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // configuration write, block must be idle; tracks the local register copy
  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_OFFSET_X:       disp_cfg[0] = val;
      REG_OFFSET_Y:       disp_cfg[1] = val;
      REG_OFFSET_Z:       disp_cfg[2] = val;
      REG_SHADOW_RGBA:    shadow_cfg = val;
      REG_GRADIENT_RGBA:  gradient_cfg = val;
      REG_SEGMENTS:       seg_cfg = val[SEG_W-1:0];
      REG_USE_GRADIENT:   gradient_on = val[0];
      REG_MULTIPLY_ALPHA: alpha_mul_on = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one vertex beat, with an optional burst gap before it
  task automatic offer_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [7:0] src_a);
    int unsigned gap;
    if (tx_gap_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left != 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {src_a, pz, py, px};
    do @(posedge clk); while (!s_axis_tready);
    extrude_vertex(px, py, pz, src_a);
  endtask

  // stop sending and wait for every expected copy, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_copies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic offer_random_vertex();
    offer_vertex(pick_word(), pick_word(), pick_word(), pick_alpha());
  endtask

  // receiver: long hold on request, otherwise always ready or, with stalls enabled, alternating ready and stall runs
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      m_axis_tready <= 1'b0;
      hold_left <= LONG_HOLD;
    end else if (!rx_stall_en) begin
      m_axis_tready <= 1'b1;
    end else if (rx_run_left == 0) begin
      m_axis_tready <= !m_axis_tready;
      rx_run_left <= m_axis_tready ? $urandom_range(1, 6) : $urandom_range(1, 16);
    end else begin
      rx_run_left <= rx_run_left - 1;
    end
  end

  // result checker: every copy beat against the oldest expectation
  always @(posedge clk) begin
    shadow_copy_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_copies.size() == 0) begin
        $error("unexpected shadow copy beat: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_copies.pop_front();
        compare_field("out_x", want.pos[0], m_axis_tdata[31:0]);
        compare_field("out_y", want.pos[1], m_axis_tdata[63:32]);
        compare_field("out_z", want.pos[2], m_axis_tdata[95:64]);
        compare_field("red", 32'(want.color[0]), 32'(m_axis_tdata[103:96]));
        compare_field("green", 32'(want.color[1]), 32'(m_axis_tdata[111:104]));
        compare_field("blue", 32'(want.color[2]), 32'(m_axis_tdata[119:112]));
        compare_field("alpha", 32'(want.color[3]), 32'(m_axis_tdata[127:120]));
        compare_field("copy_index", 32'(want.idx), 32'(m_axis_tdata[133:128]));
        compare_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // reset values: one copy, no displacement, opaque black
  task automatic test_reset_state();
    offer_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 8'hFF);
    offer_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'h00);
    drain();
  endtask

  // positions that wrap, and negative displacement truncating toward zero
  task automatic test_wrap_truncation();
    write_reg(REG_OFFSET_X, 32'h7FFF_FFFF);
    write_reg(REG_OFFSET_Y, 32'h8000_0000);
    write_reg(REG_OFFSET_Z, 32'hFFFF_FFFF);
    write_reg(REG_SEGMENTS, 32'd2);
    offer_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 8'h80);
    offer_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 8'h01);
    drain();
    write_reg(REG_OFFSET_Z, 32'hFFFF_FFFD);
    offer_vertex(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 8'hFE);
    drain();
  endtask

  // most copies per vertex
  task automatic test_max_segments();
    write_reg(REG_SEGMENTS, 32'd63);
    write_reg(REG_OFFSET_X, 32'h0040_0000);
    write_reg(REG_OFFSET_Y, 32'hFFC0_0001);
    offer_vertex(32'h1234_5678, 32'h8765_4321, 32'h0, 8'hFF);
    offer_vertex(32'h7FFF_0000, 32'h8000_FFFF, 32'hFFFF_FFFF, 8'h00);
    drain();
  endtask

  // gradient blend with alpha scaling, then alpha scaling alone
  task automatic test_gradient_alpha();
    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
    write_reg(REG_SEGMENTS, 32'd5);
    write_reg(REG_SHADOW_RGBA, 32'hFFFF_FFFF);
    write_reg(REG_GRADIENT_RGBA, 32'h0000_0000);
    write_reg(REG_USE_GRADIENT, 32'd1);
    write_reg(REG_MULTIPLY_ALPHA, 32'd1);
    offer_vertex(32'h0, 32'h0, 32'h0, 8'h00);
    offer_vertex(32'h0, 32'h0, 32'h0, 8'hFF);
    offer_vertex(32'h0, 32'h0, 32'h0, 8'h80);
    drain();
    write_reg(REG_SHADOW_RGBA, 32'h1234_5678);
    write_reg(REG_GRADIENT_RGBA, 32'hFEDC_BA98);
    offer_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 8'h7F);
    offer_vertex(32'h0, 32'h0, 32'h0, 8'hFF);
    drain();
    write_reg(REG_USE_GRADIENT, 32'd0);
    offer_vertex(32'h0, 32'h0, 32'h0, 8'hAB);
    offer_vertex(32'h0, 32'h0, 32'h0, 8'h00);
    drain();
    write_reg(REG_MULTIPLY_ALPHA, 32'd0);
  endtask

  // output held off for a long stretch while vertices keep arriving
  task automatic test_backpressure();
    tx_gap_en = 1'b0;
    rx_stall_en = 1'b0;
    write_reg(REG_SEGMENTS, 32'd15);
    write_reg(REG_USE_GRADIENT, 32'd1);
    hold_req <= 1'b1;
    repeat (6) offer_random_vertex();
    drain();
  endtask

  // random register settings per phase, random vertices within each
  task automatic test_random();
    logic [31:0] seg;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tx_gap_en = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_stall_en = (p != 0) && ($urandom_range(0, 3) != 0);
      case (p)
        3: seg = 32'd63;
        5: seg = 32'd0;
        default: seg = $urandom_range(1, 12);
      endcase
      write_reg(REG_OFFSET_X, pick_word());
      write_reg(REG_OFFSET_Y, pick_word());
      write_reg(REG_OFFSET_Z, pick_word());
      write_reg(REG_SHADOW_RGBA, pick_word());
      write_reg(REG_GRADIENT_RGBA, pick_word());
      write_reg(REG_SEGMENTS, seg);
      write_reg(REG_USE_GRADIENT, $urandom_range(0, 1));
      write_reg(REG_MULTIPLY_ALPHA, $urandom_range(0, 1));
      repeat (VERTS_PER_PHASE) offer_random_vertex();
      drain();
    end
  endtask

  initial begin
    disp_cfg = '0;
    shadow_cfg = 32'h0000_00FF;
    gradient_cfg = 32'h0000_00FF;
    seg_cfg = '0;
    gradient_on = 1'b0;
    alpha_mul_on = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_wrap_truncation();
    test_max_segments();
    test_gradient_alpha();
    test_backpressure();
    test_random();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- long_shadow_vertex_expander_top.f -----
src/lsve_pkg.sv
src/long_shadow_vertex_expander_top.sv
src/lsve_checker.sv
bench/tb.sv
